@@ hdl/sdq_pkg.sv @@
// ----------------------------------------------------------------------------
// sdq_pkg
// Shared types, constants and helpers for the sorted deadline queue.
// ----------------------------------------------------------------------------
package sdq_pkg;

	localparam int DEPTH = 32;
	localparam int IDX_W = $clog2(DEPTH);

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_EXPIRED = 2'd0,
		KIND_WAIT    = 2'd1,
		KIND_EMPTY   = 2'd2
	} kind_t;

	typedef struct packed {
		op_t         opcode;
		logic [31:0] now;
		logic [15:0] delay;
		logic [6:0]  handle;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [6:0]  expired_handle;
		logic [31:0] wait_time;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [31:0] deadline;
		logic [6:0]  handle;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_PREP,
		ST_EXPIRE
	} state_t;

	typedef enum logic [1:0] {
		PTR_HOLD,
		PTR_INC,
		PTR_TAIL
	} ptr_sel_t;

	typedef enum logic {
		WR_NEW,
		WR_CARRY
	} wr_sel_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_EXPIRED,
		EMIT_SUMMARY
	} emit_t;

	typedef struct packed {
		logic     load;
		ptr_sel_t ptr_sel;
		logic     wr_en;
		wr_sel_t  wr_sel;
		logic     wr_at_head;
		logic     carry_load;
		logic     head_inc;
		logic     tail_inc;
		emit_t    emit;
	} cmd_t;

	typedef struct packed {
		logic insert_op;
		logic at_head;
		logic before_new;
		logic same_handle;
		logic due;
		logic full;
		logic empty;
		logic out_free;
	} status_t;

	function automatic idx_t next_idx(input idx_t i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

endpackage

@@ hdl/sdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// sdq_ctrl
// Sequencer for the deadline queue: sorted insert walk, shift, then expiry.
// ----------------------------------------------------------------------------
module sdq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  sdq_pkg::status_t st,
	output sdq_pkg::cmd_t    cmd
);
	import sdq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		cmd.load       = 1'b0;
		cmd.ptr_sel    = PTR_HOLD;
		cmd.wr_en      = 1'b0;
		cmd.wr_sel     = WR_NEW;
		cmd.wr_at_head = 1'b0;
		cmd.carry_load = 1'b0;
		cmd.head_inc   = 1'b0;
		cmd.tail_inc   = 1'b0;
		cmd.emit       = EMIT_NONE;
		item_stall     = (state_q != ST_IDLE);

		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load    = 1'b1;
					cmd.ptr_sel = PTR_TAIL;
					state_d     = st.insert_op ? ST_SCAN : ST_EXPIRE;
				end
			end
			ST_SCAN: begin
				priority if (st.at_head) begin
					if (!st.full) begin
						cmd.wr_en      = 1'b1;
						cmd.wr_sel     = WR_NEW;
						cmd.wr_at_head = 1'b1;
						cmd.head_inc   = 1'b1;
					end
					cmd.ptr_sel = PTR_TAIL;
					state_d     = ST_PREP;
				end else if (st.before_new) begin
					if (st.same_handle) begin
						cmd.ptr_sel = PTR_TAIL;
						state_d     = ST_PREP;
					end else begin
						cmd.ptr_sel = PTR_INC;
					end
				end else begin
					cmd.wr_en      = 1'b1;
					cmd.wr_sel     = WR_NEW;
					cmd.carry_load = 1'b1;
					cmd.ptr_sel    = PTR_INC;
					state_d        = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (st.at_head) begin
					if (!st.full) begin
						cmd.wr_en      = 1'b1;
						cmd.wr_sel     = WR_CARRY;
						cmd.wr_at_head = 1'b1;
						cmd.head_inc   = 1'b1;
					end
					cmd.ptr_sel = PTR_TAIL;
					state_d     = ST_PREP;
				end else begin
					cmd.wr_en      = 1'b1;
					cmd.wr_sel     = WR_CARRY;
					cmd.carry_load = 1'b1;
					cmd.ptr_sel    = PTR_INC;
				end
			end
			ST_PREP: begin
				// re-read the tail slot after the last write has landed
				state_d = ST_EXPIRE;
			end
			ST_EXPIRE: begin
				if (st.out_free) begin
					if (!st.empty && st.due) begin
						cmd.emit     = EMIT_EXPIRED;
						cmd.tail_inc = 1'b1;
						cmd.ptr_sel  = PTR_INC;
					end else begin
						cmd.emit = EMIT_SUMMARY;
						state_d  = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/sdq_dp.sv @@
// ----------------------------------------------------------------------------
// sdq_dp
// Datapath: deadline ring memory, ring pointers, walk carry and result register.
// ----------------------------------------------------------------------------
module sdq_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  sdq_pkg::item_t    item,
	input  sdq_pkg::cmd_t     cmd,
	output sdq_pkg::status_t  st,
	output logic              result_valid,
	input  logic              result_stall,
	output sdq_pkg::result_t  result
);
	import sdq_pkg::*;

	entry_t      mem [DEPTH];
	entry_t      rd_q;
	entry_t      carry_q;
	entry_t      wr_data;
	idx_t        wr_addr;

	idx_t        ptr_q;
	idx_t        ptr_d;
	idx_t        head_q;
	idx_t        tail_q;

	logic [31:0] now_q;
	logic [31:0] when_q;
	logic [6:0]  handle_q;

	logic        out_valid_q;
	result_t     out_q;
	result_t     out_d;

	always_comb begin
		unique case (cmd.ptr_sel)
			PTR_INC:  ptr_d = next_idx(ptr_q);
			PTR_TAIL: ptr_d = tail_q;
			default:  ptr_d = ptr_q;
		endcase
	end

	assign wr_data = (cmd.wr_sel == WR_NEW) ? entry_t'{deadline: when_q, handle: handle_q}
	                                        : carry_q;
	assign wr_addr = cmd.wr_at_head ? head_q : ptr_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[ptr_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			ptr_q <= ptr_d;
			if (cmd.head_inc) begin
				head_q <= next_idx(head_q);
			end
			if (cmd.tail_inc) begin
				tail_q <= next_idx(tail_q);
			end
			if (cmd.emit != EMIT_NONE) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		out_d.kind           = KIND_EXPIRED;
		out_d.expired_handle = '0;
		out_d.wait_time      = '0;
		out_d.last           = 1'b0;
		unique case (cmd.emit)
			EMIT_EXPIRED: begin
				out_d.expired_handle = rd_q.handle;
			end
			EMIT_SUMMARY: begin
				out_d.last = 1'b1;
				if (st.empty) begin
					out_d.kind = KIND_EMPTY;
				end else begin
					out_d.kind      = KIND_WAIT;
					out_d.wait_time = rd_q.deadline - now_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q    <= item.now;
			when_q   <= item.now + 32'(item.delay);
			handle_q <= item.handle;
		end
		if (cmd.carry_load) begin
			carry_q <= rd_q;
		end
		if (cmd.emit != EMIT_NONE) begin
			out_q <= out_d;
		end
	end

	assign st.insert_op   = (item.opcode == OP_INSERT);
	assign st.at_head     = (ptr_q == head_q);
	assign st.before_new  = (rd_q.deadline < when_q);
	assign st.same_handle = (rd_q.handle == handle_q);
	assign st.due         = (rd_q.deadline <= now_q);
	assign st.full        = (tail_q == next_idx(head_q));
	assign st.empty       = (tail_q == head_q);
	assign st.out_free    = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

@@ hdl/sorted_deadline_queue_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_deadline_queue_unit
// Sorted timer queue: inserts deadlines in order and expires those that are due.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time. An insert walks the ring from the
// earliest entry one slot per cycle through the ring memory, which has one write
// and one read port, until it finds its place, then shifts the later entries back
// one slot per cycle; a settle step then re-reads the tail slot. Expiry emits one
// expired entry per cycle while the result side does not stall, then a closing
// summary. The next transaction is taken once the summary has been loaded into
// the result register.
module sorted_deadline_queue_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  sdq_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output sdq_pkg::result_t result
);
	import sdq_pkg::*;

	cmd_t    cmd;
	status_t st;

	sdq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.st         (st),
		.cmd        (cmd)
	);

	sdq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.st           (st),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef SYNTHESIS
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit != EMIT_NONE) |-> st.out_free)
		else $error("result emitted while result register is occupied");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("new transaction taken before previous one finished");

	a_last_is_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last) |-> (result.kind == KIND_EXPIRED))
		else $error("summary result without last flag");
`endif

endmodule
